// ===== src/ascts_pkg.sv =====
// Shared types and constants for the ADC channel scan trimmed-sum block.
`timescale 1ns / 1ps

package ascts_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int SUM_W      = 16;
	localparam int CH_W       = 2;
	localparam int MUX_W      = 8;
	localparam int NUM_MUX    = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 32;

	localparam logic [SAMPLE_W-1:0] SAMPLE_ALL_ONES = '1;

	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MUX_CH0 = 8'd0,
		REG_MUX_CH1 = 8'd1,
		REG_MUX_CH2 = 8'd2,
		REG_MUX_CH3 = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic             is_start;
		logic [CH_W-1:0]  channel;
		logic [SUM_W-1:0] trimmed_sum;
		logic             scan_done;
		logic [MUX_W-1:0] next_mux;
	} result_t;

endpackage

// ===== src/ascts_core.sv =====
// Burst accumulator: running sum, max/min tracking, trim and channel sequencing.
`timescale 1ns / 1ps

module ascts_core #(
	parameter int SAMPLES_PER_CHANNEL = 8,
	parameter int NUM_CHANNELS        = 4
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     fire,
	input  logic                                     opcode,
	input  logic [ascts_pkg::SAMPLE_W-1:0]           sample,
	input  logic [ascts_pkg::MUX_W-1:0]              mux_code [ascts_pkg::NUM_MUX],
	output logic                                     res_valid,
	output ascts_pkg::result_t                       res
);
	import ascts_pkg::*;

	localparam int IDX_W = $clog2(SAMPLES_PER_CHANNEL);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_CHANNEL - 1);
	localparam logic [CH_W-1:0]  LAST_CH  = CH_W'(NUM_CHANNELS - 1);

	logic [IDX_W-1:0]    idx_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [CH_W-1:0]     ch_q;

	logic                restart;
	logic                first;
	logic                last;
	logic [SUM_W-1:0]    sum_n;
	logic [SAMPLE_W-1:0] max_n;
	logic [SAMPLE_W-1:0] min_n;
	logic                wrap;
	logic [CH_W-1:0]     ch_n;

	assign restart = (opcode == OP_RESTART);
	assign first   = (idx_q == '0);
	assign last    = (idx_q == LAST_IDX);

	// settling sample at the head of a burst is dropped
	assign sum_n = first ? sum_q : sum_q + SUM_W'(sample);
	assign max_n = (!first && sample > max_q) ? sample : max_q;
	assign min_n = (!first && sample < min_q) ? sample : min_q;

	assign wrap = (ch_q == LAST_CH);
	assign ch_n = wrap ? '0 : ch_q + CH_W'(1);

	always_comb begin
		res_valid = fire && (restart || last);
		if (restart) begin
			res.is_start    = 1'b1;
			res.channel     = '0;
			res.trimmed_sum = '0;
			res.scan_done   = 1'b0;
			res.next_mux    = mux_code[0];
		end else begin
			res.is_start    = 1'b0;
			res.channel     = ch_q;
			res.trimmed_sum = sum_n - (SUM_W'(max_n) + SUM_W'(min_n));
			res.scan_done   = wrap;
			res.next_mux    = mux_code[ch_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			max_q <= '0;
			min_q <= SAMPLE_ALL_ONES;
			ch_q  <= '0;
		end else if (fire) begin
			if (restart || last) begin
				idx_q <= '0;
				sum_q <= '0;
				max_q <= '0;
				min_q <= SAMPLE_ALL_ONES;
				ch_q  <= restart ? '0 : ch_n;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				sum_q <= sum_n;
				max_q <= max_n;
				min_q <= min_n;
			end
		end
	end

endmodule

// ===== src/ascts_obuf.sv =====
// Result register with a skid slot so input keeps flowing under backpressure.
`timescale 1ns / 1ps

module ascts_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ascts_pkg::result_t in_data,
	output logic               in_ready,
	output logic               out_valid,
	output ascts_pkg::result_t out_data,
	input  logic               out_ready
);
	import ascts_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_valid) begin
				out_q <= in_data;
			end
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

endmodule

// ===== src/adc_channel_scan_trimmed_sum.sv =====
// Top level of the ADC channel scan trimmed-sum block.
`timescale 1ns / 1ps

// Takes converter samples for the current scan channel in bursts of
// SAMPLES_PER_CHANNEL. The first sample of each burst is dropped for settling;
// the rest are summed (mod 2^16) while max and min are tracked, and on the last
// sample of the burst one result is sent: sum minus (max + min), mod 2^16, for
// that channel, the mux code of the next channel round-robin over NUM_CHANNELS,
// and tlast when the pass over all channels completes. A restart transaction
// (tuser = 1) goes back to channel 0 and sends one result with tuser set,
// zero sum and channel 0's mux code. Samples before any restart count as a
// channel 0 burst. Throughput is one transaction per cycle: an input register
// feeds one add/compare/subtract stage into a result register that has a skid
// slot, so s_axis_tready only drops when the skid slot is occupied. With the
// result side free, an accepted transaction goes through the input register
// and then the result register, which drives m_axis_tvalid. Mux codes are
// written through the cfg port (index 0..3, other indexes ignored) and should
// only be changed while the block is idle.

module adc_channel_scan_trimmed_sum #(
	parameter int SAMPLES_PER_CHANNEL = 8,  // 3..64
	parameter int NUM_CHANNELS        = 4   // 1..4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ascts_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [9:0] sample, rest zero
	input  logic                                s_axis_tuser,  // [0] opcode (1 = restart)
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [ascts_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [1:0] channel,
	                                                           // [17:2] trimmed_sum,
	                                                           // [25:18] next_mux, rest 0
	output logic                                m_axis_tuser,  // [0] is_start
	output logic                                m_axis_tlast,  // scan_done
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ascts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ascts_pkg::MUX_W-1:0]         cfg_data
);
	import ascts_pkg::*;

	// mux code registers
	logic [MUX_W-1:0] mux_code_q [NUM_MUX];

	// input stage
	logic                valid_s1;
	logic                opcode_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	logic    obuf_ready;
	logic    fire;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MUX; i++) begin
				mux_code_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MUX_CH0: mux_code_q[0] <= cfg_data;
				REG_MUX_CH1: mux_code_q[1] <= cfg_data;
				REG_MUX_CH2: mux_code_q[2] <= cfg_data;
				REG_MUX_CH3: mux_code_q[3] <= cfg_data;
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	// the held item moves on whenever the result side has room
	assign fire          = valid_s1 && obuf_ready;
	assign s_axis_tready = !valid_s1 || obuf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[SAMPLE_W-1:0];
		end
	end

	ascts_core #(
		.SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL),
		.NUM_CHANNELS       (NUM_CHANNELS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.opcode   (opcode_s1),
		.sample   (sample_s1),
		.mux_code (mux_code_q),
		.res_valid(res_valid),
		.res      (res)
	);

	ascts_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res),
		.in_ready (obuf_ready),
		.out_valid(m_axis_tvalid),
		.out_data (out_res),
		.out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {
		(M_TDATA_W - MUX_W - SUM_W - CH_W)'(0),
		out_res.next_mux,
		out_res.trimmed_sum,
		out_res.channel
	};
	assign m_axis_tuser = out_res.is_start;
	assign m_axis_tlast = out_res.scan_done;

endmodule

// ===== src/ascts_checker.sv =====
// Port-level checks for the ADC channel scan trimmed-sum block, bound to the top.
`timescale 1ns / 1ps

module ascts_checker #(
	parameter int NUM_CHANNELS = 4
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [ascts_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser,
	input logic                            m_axis_tlast
);
	import ascts_pkg::*;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	// restart answer carries channel 0, zero sum and never closes a scan
	a_restart_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[CH_W+SUM_W-1:0] == '0 && !m_axis_tlast)
		else $error("restart result with nonzero channel/sum or tlast");

	// a scan only completes on the last channel
	a_scan_done_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[CH_W-1:0] == LAST_CH)
		else $error("scan_done reported on a channel other than the last");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

endmodule

bind adc_channel_scan_trimmed_sum ascts_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_ascts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

// ===== verif/tb_adc_channel_scan_trimmed_sum.sv =====
// Self-checking testbench for the ADC channel scan trimmed-sum block.
`timescale 1ns / 1ps

// Samples and restarts go in on the input stream. A cycle-free predictor works out
// the trimmed sum per burst, the round-robin channel and the next mux code for
// every accepted input transaction. A monitor checks each result transaction
// against the oldest prediction. Mux codes are reprogrammed only while the block
// is idle. The directed part comes first, then random runs with different
// settings and different amounts of idling on both sides.

module tb_adc_channel_scan_trimmed_sum;

	import ascts_pkg::*;

	localparam int SPC        = 8;     // samples per burst
	localparam int NCH        = 4;     // channels in one scan
	localparam int QUIET_MAX  = 2000;  // cycles with no transaction before giving up
	localparam int SETTLE     = 8;     // cycles after the last result, pipe is 2 deep
	localparam int SUM_LSB    = CH_W;
	localparam int MUX_LSB    = CH_W + SUM_W;
	localparam int RAND_RUNS  = 6;
	localparam int RUN_ITEMS  = 135;

	typedef struct {
		op_t                 op;
		logic [SAMPLE_W-1:0] smp;
		int unsigned         gap;   // idle cycles ahead of this transaction
	} sample_txn_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [MUX_W-1:0]     cfg_data      = '0;

	adc_channel_scan_trimmed_sum #(
		.SAMPLES_PER_CHANNEL(SPC),
		.NUM_CHANNELS(NCH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: burst accumulators, scan position and mux codes
	// ---------------------------------------------------------------------
	int unsigned         burst_pos = 0;
	logic [SUM_W-1:0]    burst_sum = '0;
	logic [SAMPLE_W-1:0] burst_max = '0;
	logic [SAMPLE_W-1:0] burst_min = SAMPLE_ALL_ONES;
	logic [CH_W-1:0]     scan_ch   = '0;
	logic [MUX_W-1:0]    mux_table [NUM_MUX] = '{default: '0};

	sample_txn_t samples_to_send [$];
	result_t     sums_due [$];

	// handshake flags, refreshed at every rising edge by the monitor
	logic in_taken  = 1'b0;
	logic out_taken = 1'b0;

	int unsigned send_gap_max   = 0;
	int unsigned sink_stall_max = 0;
	int unsigned mismatches     = 0;
	int unsigned quiet_cycles   = 0;

	task automatic predict_trimmed_sum(input op_t op, input logic [SAMPLE_W-1:0] smp);
		result_t r;
		if (op == OP_RESTART) begin
			burst_pos     = 0;
			burst_sum     = '0;
			burst_max     = '0;
			burst_min     = SAMPLE_ALL_ONES;
			scan_ch       = '0;
			r.is_start    = 1'b1;
			r.channel     = '0;
			r.trimmed_sum = '0;
			r.scan_done   = 1'b0;
			r.next_mux    = mux_table[0];
			sums_due.push_back(r);
			return;
		end
		// first sample of a burst is settling and is dropped
		if (burst_pos != 0) begin
			burst_sum = burst_sum + SUM_W'(smp);
			if (smp > burst_max)
				burst_max = smp;
			if (smp < burst_min)
				burst_min = smp;
		end
		if (burst_pos + 1 < SPC) begin
			burst_pos++;
			return;
		end
		r.is_start    = 1'b0;
		r.channel     = scan_ch;
		r.trimmed_sum = burst_sum - (SUM_W'(burst_max) + SUM_W'(burst_min));
		r.scan_done   = (scan_ch == NCH - 1);
		scan_ch       = (scan_ch == NCH - 1) ? '0 : scan_ch + 1'b1;
		r.next_mux    = mux_table[scan_ch];
		sums_due.push_back(r);
		burst_pos = 0;
		burst_sum = '0;
		burst_max = '0;
		burst_min = SAMPLE_ALL_ONES;
	endtask

	// ---------------------------------------------------------------------
	// Input driver: pops the queue, holds each transaction until accepted
	// ---------------------------------------------------------------------
	sample_txn_t cur_txn;
	logic        have_txn = 1'b0;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (!have_txn && samples_to_send.size() != 0) begin
					cur_txn  = samples_to_send.pop_front();
					have_txn = 1'b1;
					gap_left = cur_txn.gap;
				end
				if (have_txn && gap_left == 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= cur_txn.op;
					s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, cur_txn.smp};
					have_txn = 1'b0;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (have_txn)
						gap_left--;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result sink: stalls a random number of cycles after each transaction
	// ---------------------------------------------------------------------
	int unsigned stall_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken)
				stall_left = $urandom_range(0, sink_stall_max);
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: register shadow, result check, prediction, watchdog
	// ---------------------------------------------------------------------
	result_t got;
	result_t want;
	logic    cfg_taken;

	always @(posedge clk) begin
		in_taken  = arst_n && s_axis_tvalid && s_axis_tready;
		out_taken = arst_n && m_axis_tvalid && m_axis_tready;
		cfg_taken = arst_n && cfg_valid && cfg_ready;

		// indexes past the mux table are ignored by the block
		if (cfg_taken && cfg_index < NUM_MUX)
			mux_table[cfg_index] = cfg_data;

		// check before predicting: a result never answers a same-edge input
		if (out_taken) begin
			got.is_start    = m_axis_tuser;
			got.channel     = m_axis_tdata[CH_W-1:0];
			got.trimmed_sum = m_axis_tdata[SUM_LSB +: SUM_W];
			got.scan_done   = m_axis_tlast;
			got.next_mux    = m_axis_tdata[MUX_LSB +: MUX_W];
			if (sums_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: start=%0b ch=%0d sum=%0d done=%0b mux=%02h",
						$realtime, got.is_start, got.channel, got.trimmed_sum,
						got.scan_done, got.next_mux);
			end else begin
				want = sums_due.pop_front();
				if (got.is_start !== want.is_start || got.channel !== want.channel ||
					got.trimmed_sum !== want.trimmed_sum ||
					got.scan_done !== want.scan_done || got.next_mux !== want.next_mux ||
					m_axis_tdata[M_TDATA_W-1:MUX_LSB+MUX_W] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected start=%0b ch=%0d sum=%0d done=%0b mux=%02h, got start=%0b ch=%0d sum=%0d done=%0b mux=%02h tdata=%08h",
							$realtime, want.is_start, want.channel, want.trimmed_sum,
							want.scan_done, want.next_mux, got.is_start, got.channel,
							got.trimmed_sum, got.scan_done, got.next_mux, m_axis_tdata);
				end
			end
		end

		if (in_taken)
			predict_trimmed_sum(op_t'(s_axis_tuser), s_axis_tdata[SAMPLE_W-1:0]);

		if (in_taken || out_taken || cfg_taken)
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("adc_channel_scan_trimmed_sum regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic queue_item(input op_t op, input logic [SAMPLE_W-1:0] smp);
		sample_txn_t t;
		t.op  = op;
		t.smp = smp;
		t.gap = $urandom_range(0, send_gap_max);
		samples_to_send.push_back(t);
	endtask

	// extremes and a tight cluster turn up often, so min/max ties happen
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return SAMPLE_ALL_ONES;
			2:       return SAMPLE_W'($urandom_range(500, 520));
			default: return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
		endcase
	endfunction

	// one register transaction; only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MUX_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// everything sent and answered, then let bursts still in flight settle
	task automatic wait_idle();
		while (samples_to_send.size() != 0 || have_txn || s_axis_tvalid ||
			sums_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin : stimulus
		int          run;
		int          k;
		logic [MUX_W-1:0] code;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// burst before any restart counts as channel 0, mux codes still at reset;
		// the dropped first sample is an extreme that must not leak into the sum
		queue_item(OP_SAMPLE, SAMPLE_ALL_ONES);
		queue_item(OP_SAMPLE, '0);
		queue_item(OP_SAMPLE, SAMPLE_ALL_ONES);
		queue_item(OP_SAMPLE, '0);
		queue_item(OP_SAMPLE, 10'd341);
		queue_item(OP_SAMPLE, 10'd682);
		queue_item(OP_SAMPLE, 10'd1);
		queue_item(OP_SAMPLE, 10'd1022);
		wait_idle();

		// extreme and alternating codes, plus writes to unused indexes
		write_reg(REG_MUX_CH0, 8'hff);
		write_reg(REG_MUX_CH1, 8'h00);
		write_reg(REG_MUX_CH2, 8'ha5);
		write_reg(REG_MUX_CH3, 8'h5a);
		write_reg(CFG_IDX_W'(NUM_MUX), 8'h77);
		write_reg('1, 8'h33);

		send_gap_max   = 3;
		sink_stall_max = 3;
		// restart, then a burst with a low settling sample and all others full scale
		queue_item(OP_RESTART, SAMPLE_ALL_ONES);
		queue_item(OP_SAMPLE, '0);
		for (k = 1; k < SPC; k++)
			queue_item(OP_SAMPLE, SAMPLE_ALL_ONES);
		// restart in the middle of a burst drops the partial accumulation
		queue_item(OP_SAMPLE, 10'd5);
		queue_item(OP_SAMPLE, 10'd6);
		queue_item(OP_SAMPLE, 10'd7);
		queue_item(OP_RESTART, '0);
		wait_idle();

		// random runs: mostly complete bursts, rare restarts break them up
		for (run = 0; run < RAND_RUNS; run++) begin
			for (k = 0; k < NUM_MUX; k++) begin
				case (run)
					1:       code = '0;
					2:       code = '1;
					default: code = MUX_W'($urandom);
				endcase
				write_reg(CFG_IDX_W'(k), code);
			end
			write_reg(CFG_IDX_W'($urandom_range(NUM_MUX, (1 << CFG_IDX_W) - 1)),
				MUX_W'($urandom));

			case (run % 4)
				0: begin send_gap_max = 0;  sink_stall_max = 0;  end
				1: begin send_gap_max = 16; sink_stall_max = 16; end
				2: begin send_gap_max = 0;  sink_stall_max = 16; end
				default: begin send_gap_max = 16; sink_stall_max = 0; end
			endcase

			for (k = 0; k < RUN_ITEMS; k++) begin
				if ($urandom_range(0, 39) == 0)
					queue_item(OP_RESTART, pick_sample());
				else
					queue_item(OP_SAMPLE, pick_sample());
			end
			wait_idle();
		end

		if (mismatches == 0 && sums_due.size() == 0)
			$display("adc_channel_scan_trimmed_sum regression: pass");
		else
			$display("adc_channel_scan_trimmed_sum regression: fail");
		$finish;
	end

endmodule

// ===== adc_channel_scan_trimmed_sum.f =====
src/ascts_pkg.sv
src/ascts_core.sv
src/ascts_obuf.sv
src/adc_channel_scan_trimmed_sum.sv
src/ascts_checker.sv
verif/tb_adc_channel_scan_trimmed_sum.sv
